@@ design/zero_run_length_decoder_core_defines.svh @@
// Assertion macros for the zero run-length decoder core.
// Each macro expects clk and rst in scope at the point of use.
`ifndef ZERO_RUN_LENGTH_DECODER_CORE_DEFINES_SVH
`define ZERO_RUN_LENGTH_DECODER_CORE_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define ZRLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the next edge after the antecedent.
`define ZRLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/zrld_pkg.sv @@
// Shared types and constants for the zero run-length decoder.
// No dependencies.
package zrld_pkg;

  localparam int DEST_ADDR_BITS_DEF = 24;
  localparam int LIMIT_W            = 25;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;
  localparam int OFFSET_W           = 24;
  localparam int NIBBLE_W           = 4;
  localparam logic [NIBBLE_W-1:0] NIBBLE_MAX = 4'hF;

  // Result queue depth; two free entries are needed to take a word.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_END     = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_LITERAL = 3'b010,
    PH_EXTEND  = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t               kind;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          value;
    logic [7:0]          run_length;
    logic                last;
  } result_t;

  // Results produced by one accepted word.
  typedef struct packed {
    logic [1:0] n;
    logic       done;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

endpackage

@@ design/zrld_in_if.sv @@
// Input channel: one compressed byte per word.
// No dependencies.
interface zrld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;

  modport source (output valid, output compressed_byte, input ready);
  modport sink (input valid, input compressed_byte, output ready);
endinterface

@@ design/zrld_out_if.sv @@
// Result channel: one destination write per word.
// No dependencies.
interface zrld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] offset;
  logic [7:0]  value;
  logic [7:0]  run_length;
  logic        last;

  modport source (output valid, output kind, output offset, output value,
                  output run_length, output last, input ready);
  modport sink (input valid, input kind, input offset, input value,
                input run_length, input last, output ready);
endinterface

@@ design/zrld_cfg_if.sv @@
// Configuration write channel carrying the destination limit.
// No dependencies.
interface zrld_cfg_if;
  logic        valid;
  logic        ready;
  logic [24:0] dest_limit;

  modport source (output valid, output dest_limit, input ready);
  modport sink (input valid, input dest_limit, output ready);
endinterface

@@ design/zero_run_length_decoder_core.sv @@
// Top level of the zero run-length decoder: limit register, decoder and
// result queue. Uses zrld_pkg, the channel interfaces and the assert macros.
//
//  channel  dir  payload                                   handshake
//  stream   in   compressed_byte[7:0]                      valid/ready
//  writes   out  kind, offset, value, run_length, last     valid/ready
//  cfg      in   dest_limit[24:0]                          valid/ready
//
// One byte is accepted per cycle; its results land in the queue the same
// edge and the first is visible the next cycle. A byte with a literal and
// a zero run yields two results, so the output port sets the rate then.
// stream.ready drops while fewer than two queue entries are free.
// rst is synchronous; it clears decoder state and queue and sets dest_limit to LIMIT_RESET.
// stream.ready and cfg.ready stay low while rst is high.
`include "zero_run_length_decoder_core_defines.svh"

module zero_run_length_decoder_core #(
  parameter int DEST_ADDR_BITS = zrld_pkg::DEST_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  zrld_in_if.sink     stream,
  zrld_out_if.source  writes,
  zrld_cfg_if.sink    cfg
);
  import zrld_pkg::*;

  logic [LIMIT_W-1:0] dest_limit;
  logic               accept;
  push_t              push;
  q_stat_t            stat;

  assign cfg.ready    = !rst;
  assign stream.ready = !rst && (stat.count <= Q_CNT_W'(Q_DEPTH - 2));
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_limit <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      dest_limit <= cfg.dest_limit;
    end
  end

  zrld_decoder #(
    .DEST_ADDR_BITS(DEST_ADDR_BITS)
  ) u_decoder (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (stream.compressed_byte),
    .limit  (dest_limit),
    .push   (push)
  );

  zrld_result_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .out  (writes),
    .stat (stat)
  );

  `ZRLD_ASSERT_SAME(a_q_no_overflow, push.n != 2'd0, (Q_CNT_W + 1)'(stat.count) + (Q_CNT_W + 1)'(push.n) <= (Q_CNT_W + 1)'(Q_DEPTH), "result queue overflow")
  `ZRLD_ASSERT_SAME(a_done_silent, push.done, push.n == 2'd0, "result after end of image")
  `ZRLD_ASSERT_NEXT(a_end_sets_done, push.n == 2'd1 && push.r0.kind == KIND_END, push.done, "end did not stop decoder")
  `ZRLD_ASSERT_SAME(a_stop_is_last, writes.valid && (writes.kind == KIND_END || writes.kind == KIND_OVERRUN), writes.last, "stop result without last")

endmodule

@@ design/zrld_decoder.sv @@
// Decoder state and per-byte step logic: parses control, literal and
// extension bytes and forms up to two results. Uses zrld_pkg.
module zrld_decoder #(
  parameter int DEST_ADDR_BITS = zrld_pkg::DEST_ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     data,
  input  logic [zrld_pkg::LIMIT_W-1:0]   limit,
  output zrld_pkg::push_t                push
);
  import zrld_pkg::*;

  localparam int OW = DEST_ADDR_BITS + 1;
  localparam int CW = ((OW > LIMIT_W) ? OW : LIMIT_W) + 1;
  localparam logic [CW-1:0] CAP = CW'(1) << DEST_ADDR_BITS;

  phase_t                phase, phase_next;
  logic [NIBBLE_W-1:0]   literals_left, literals_left_next;
  logic [NIBBLE_W-1:0]   pending_zeros, pending_zeros_next;
  logic [OW-1:0]         dest_offset, dest_offset_next;
  logic                  finished, finished_next;

  logic [CW-1:0]         lim;
  logic [CW-1:0]         off_ext;
  logic [CW-1:0]         off_inc;
  logic [CW-1:0]         run_start;
  logic [7:0]            run_len;
  logic [CW-1:0]         run_end;
  logic                  run_over;
  result_t               run_res;
  logic [NIBBLE_W-1:0]   hi_nib, lo_nib, left_dec;
  logic [1:0]            n;
  result_t               r0, r1;

  function automatic result_t mk(kind_t k, logic [CW-1:0] off, logic [7:0] v,
                                 logic [7:0] len);
    result_t r;
    r.kind       = k;
    r.offset     = OFFSET_W'(off[DEST_ADDR_BITS-1:0]);
    r.value      = v;
    r.run_length = len;
    r.last       = 1'b0;
    return r;
  endfunction

  assign lim     = (CW'(limit) < CAP) ? CW'(limit) : CAP;
  assign off_ext = CW'(dest_offset);
  assign off_inc = off_ext + CW'(1);
  assign hi_nib  = data[7:NIBBLE_W];
  assign lo_nib  = data[NIBBLE_W-1:0];
  assign left_dec = literals_left - NIBBLE_W'(1);

  // Shared zero-run check; start and length picked by the phase.
  always_comb begin
    run_start = off_ext;
    run_len   = 8'(pending_zeros);
    case (phase)
      PH_CONTROL: run_len = 8'(lo_nib);
      PH_LITERAL: begin
        run_start = off_inc;
        run_len   = 8'(pending_zeros);
      end
      PH_EXTEND:  run_len = data;
      default:    run_len = 8'd0;
    endcase
    run_end  = run_start + CW'(run_len);
    run_over = run_end > lim;
    run_res  = run_over ? mk(KIND_OVERRUN, run_start, 8'd0, 8'd0)
                        : mk(KIND_ZERO, run_start, 8'd0, run_len);
  end

  always_comb begin
    phase_next         = phase;
    literals_left_next = literals_left;
    pending_zeros_next = pending_zeros;
    dest_offset_next   = dest_offset;
    finished_next      = finished;
    n  = 2'd0;
    r0 = run_res;
    r1 = run_res;
    if (!finished) begin
      case (phase)
        PH_CONTROL: begin
          if (data == 8'd0) begin
            r0 = mk(KIND_END, off_ext, 8'd0, 8'd0);
            n  = 2'd1;
            finished_next = 1'b1;
          end else begin
            literals_left_next = hi_nib;
            pending_zeros_next = lo_nib;
            if (hi_nib != '0) begin
              phase_next = PH_LITERAL;
            end else if (lo_nib == NIBBLE_MAX) begin
              phase_next = PH_EXTEND;
            end else begin
              n = 2'd1;
              if (run_over) finished_next = 1'b1;
              else dest_offset_next = OW'(run_end);
            end
          end
        end
        PH_LITERAL: begin
          if (off_ext >= lim) begin
            r0 = mk(KIND_OVERRUN, off_ext, 8'd0, 8'd0);
            n  = 2'd1;
            finished_next = 1'b1;
          end else begin
            r0 = mk(KIND_LITERAL, off_ext, data, 8'd1);
            n  = 2'd1;
            dest_offset_next   = OW'(off_inc);
            literals_left_next = left_dec;
            if (left_dec == '0) begin
              if (pending_zeros == NIBBLE_MAX) begin
                phase_next = PH_EXTEND;
              end else begin
                phase_next = PH_CONTROL;
                if (pending_zeros != '0) begin
                  n = 2'd2;
                  if (run_over) finished_next = 1'b1;
                  else dest_offset_next = OW'(run_end);
                end
              end
            end
          end
        end
        PH_EXTEND: begin
          phase_next = PH_CONTROL;
          if (data != 8'd0) begin
            n = 2'd1;
            if (run_over) finished_next = 1'b1;
            else dest_offset_next = OW'(run_end);
          end
        end
        default: phase_next = PH_CONTROL;
      endcase
    end
    // Flag the final result of this word.
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CONTROL;
      literals_left <= '0;
      pending_zeros <= '0;
      dest_offset   <= '0;
      finished      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      literals_left <= literals_left_next;
      pending_zeros <= pending_zeros_next;
      dest_offset   <= dest_offset_next;
      finished      <= finished_next;
    end
  end

  assign push.n    = accept ? n : 2'd0;
  assign push.done = finished;
  assign push.r0   = r0;
  assign push.r1   = r1;

endmodule

@@ design/zrld_result_queue.sv @@
// Small result queue: takes up to two results a cycle, gives one when out.ready is high.
// Uses zrld_pkg and zrld_out_if.
module zrld_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  zrld_pkg::push_t   push,
  zrld_out_if.source        out,
  output zrld_pkg::q_stat_t stat
);
  import zrld_pkg::*;

  result_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count, count_next;
  logic                 pop;
  result_t              head;

  assign pop        = out.valid && out.ready;
  assign count_next = count + Q_CNT_W'(push.n) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + Q_PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.n);
      rd_ptr <= rd_ptr + Q_PTR_W'(pop);
      count  <= count_next;
    end
  end

  assign head           = mem[rd_ptr];
  assign out.valid      = count != '0;
  assign out.kind       = head.kind;
  assign out.offset     = head.offset;
  assign out.value      = head.value;
  assign out.run_length = head.run_length;
  assign out.last       = head.last;
  assign stat.count     = count;

endmodule
